@@ hw/rtl/lap3_pkg.sv @@
// lap3_pkg: shared types and constants of the 3x3 Laplacian stream filter.
// Holds the configuration register codes, the item flag struct and the queue depth.
// No dependencies.
`timescale 1ns / 1ps

package lap3_pkg;

  // Width of the frame size registers and of the configuration data bus.
  localparam int CFG_DIM_W = 11;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEIGHBOUR_MODE = 2'd0,
    CFG_FRAME_WIDTH    = 2'd1,
    CFG_FRAME_HEIGHT   = 2'd2
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic                 RST_NEIGHBOUR_MODE = 1'b0;
  localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH    = 11'd1024;
  localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT   = 11'd1024;

  // Input item command codes.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Kernel select.
  localparam logic MODE_EIGHT = 1'b1;

  // Entries of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Classification of one item, made by the front and used by the back.
  typedef struct packed {
    logic produced;  // item yields a result
    logic done;      // result closes the frame
    logic interior;  // center is not on the frame border
  } lap3_flags_t;

endpackage

@@ hw/rtl/lap3_front.sv @@
// lap3_front: input side of the Laplacian filter. Accepts items, tracks column and row,
// classifies each item and pushes it into the queue.
// Depends on lap3_pkg.
`timescale 1ns / 1ps

module lap3_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 16,
  parameter int AW         = $clog2(MAX_WIDTH)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [PIXEL_BITS-1:0]          in_pixel,
  input  logic [lap3_pkg::CFG_DIM_W-1:0] frame_width,
  input  logic [lap3_pkg::CFG_DIM_W-1:0] frame_height,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [PIXEL_BITS-1:0]          q_pixel,
  output logic [AW-1:0]                  q_addr,
  output lap3_pkg::lap3_flags_t          q_flags
);
  import lap3_pkg::*;

  localparam int RW    = $clog2(MAX_HEIGHT + 2);
  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int HB    = $clog2(MAX_HEIGHT + 2);
  localparam int WV_W  = (WB > CFG_DIM_W) ? WB : CFG_DIM_W;
  localparam int HV_W  = (HB > CFG_DIM_W) ? HB : CFG_DIM_W;

  logic [AW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [WV_W-1:0] w_raw, w_eff, col_ext;
  logic [HV_W-1:0] h_raw, h_eff, row_ext;
  logic            accept;
  lap3_flags_t     flags;

  // Clamp the programmed sizes to the supported range.
  always_comb begin
    w_raw = WV_W'(frame_width);
    h_raw = HV_W'(frame_height);
    if (w_raw < WV_W'(3))              w_eff = WV_W'(3);
    else if (w_raw > WV_W'(MAX_WIDTH)) w_eff = WV_W'(MAX_WIDTH);
    else                               w_eff = w_raw;
    if (h_raw < HV_W'(3))               h_eff = HV_W'(3);
    else if (h_raw > HV_W'(MAX_HEIGHT)) h_eff = HV_W'(MAX_HEIGHT);
    else                                h_eff = h_raw;
  end

  assign col_ext  = WV_W'(col_r);
  assign row_ext  = HV_W'(row_r);
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Classify: column 0 carries the right border of row r-2, other columns row r-1.
  always_comb begin
    flags.done     = 1'b0;
    flags.interior = 1'b0;
    if (col_r == '0) begin
      flags.produced = (row_r >= RW'(2));
      flags.done     = (row_r >= RW'(2)) && (row_ext >= h_eff + HV_W'(1));
    end else begin
      flags.produced = (row_r >= RW'(1));
      flags.interior = (col_r >= AW'(2)) && (col_ext < w_eff) &&
                       (row_r >= RW'(2)) && (row_ext < h_eff);
    end
  end

  // Advance position; wrap at row end, restart after the closing result.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (flags.done) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_ext + WV_W'(1) >= w_eff) begin
      col_nxt = '0;
      row_nxt = row_r + RW'(1);
    end else begin
      col_nxt = AW'(col_ext + WV_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign q_push  = accept;
  assign q_pixel = (in_cmd == CMD_DRAIN) ? '0 : in_pixel;
  assign q_addr  = col_r;
  assign q_flags = flags;

endmodule

@@ hw/rtl/lap3_queue.sv @@
// lap3_queue: short register FIFO between the front and the back of the filter.
// Depends on lap3_pkg for its depth.
`timescale 1ns / 1ps

module lap3_queue #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          full,
  output logic          empty
);
  import lap3_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0] slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = count_r + CW'(1);
    else if (!push && pop) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= PW'((32'(wptr_r) + 1) % QUEUE_DEPTH);
      if (pop)  rptr_r <= PW'((32'(rptr_r) + 1) % QUEUE_DEPTH);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= push_data;
  end

endmodule

@@ hw/rtl/lap3_back.sv @@
// lap3_back: execution side of the filter. Line store, 3x3 window, kernel sums
// and the output register.
// Depends on lap3_pkg.
`timescale 1ns / 1ps

module lap3_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16,
  parameter int AW         = $clog2(MAX_WIDTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         neighbour_mode,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  logic [PIXEL_BITS-1:0]        q_pixel,
  input  logic [AW-1:0]                q_addr,
  input  lap3_pkg::lap3_flags_t        q_flags,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [PIXEL_BITS+3:0] out_laplacian,
  output logic                         out_frame_done
);
  import lap3_pkg::*;

  localparam int P  = PIXEL_BITS;
  localparam int LW = PIXEL_BITS + 4;
  localparam int SW = PIXEL_BITS + 2;

  // Line store: one entry per column, {row r-2, row r-1}.
  logic [2*P-1:0] line_mem [MAX_WIDTH];
  logic [2*P-1:0] rd_data_r;

  logic           advance;
  logic           s1_valid_r, s2_valid_r, s3_valid_r;
  logic [P-1:0]   s1_pixel_r;
  logic [AW-1:0]  s1_addr_r;
  lap3_flags_t    s1_flags_r, s2_flags_r, s3_flags_r;
  logic [P-1:0]   win_r [3][3];
  logic [P-1:0]   up1, up2;
  logic [P-1:0]   s3_center_r;
  logic [SW-1:0]  s3_edges_r, s3_corners_r;
  logic [LW-1:0]  lap_nxt;
  logic           out_valid_r, out_done_r;
  logic [LW-1:0]  out_lap_r;

  // Whole pipe moves when the output register is free or being drained.
  assign advance = !out_valid_r || !out_stall;
  assign q_pop   = advance && !q_empty;
  assign up1     = rd_data_r[P-1:0];
  assign up2     = rd_data_r[2*P-1:P];

  always_ff @(posedge clk) begin
    if (q_pop) rd_data_r <= line_mem[q_addr];
    if (advance && s1_valid_r) line_mem[s1_addr_r] <= {up1, s1_pixel_r};
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_pixel_r <= q_pixel;
      s1_addr_r  <= q_addr;
      s1_flags_r <= q_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= q_pop;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r && s3_flags_r.produced;
    end
  end

  // Shift the window one column per item; line store and item give the new column.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[k][j] <= '0;
        end
      end
    end else if (advance && s1_valid_r) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= up2;
      win_r[1][2] <= up1;
      win_r[2][2] <= s1_pixel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_flags_r   <= s1_flags_r;
      s3_flags_r   <= s2_flags_r;
      s3_center_r  <= win_r[1][1];
      s3_edges_r   <= SW'(win_r[0][1]) + SW'(win_r[2][1]) +
                      SW'(win_r[1][0]) + SW'(win_r[1][2]);
      s3_corners_r <= SW'(win_r[0][0]) + SW'(win_r[0][2]) +
                      SW'(win_r[2][0]) + SW'(win_r[2][2]);
    end
  end

  // Final subtract; border positions give zero.
  always_comb begin
    if (!s3_flags_r.interior) begin
      lap_nxt = '0;
    end else if (neighbour_mode == MODE_EIGHT) begin
      lap_nxt = (LW'(s3_center_r) << 3) - LW'(s3_edges_r) - LW'(s3_corners_r);
    end else begin
      lap_nxt = (LW'(s3_center_r) << 2) - LW'(s3_edges_r);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_lap_r  <= lap_nxt;
      out_done_r <= s3_flags_r.done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_laplacian  = $signed(out_lap_r);
  assign out_frame_done = out_done_r;

endmodule

@@ hw/rtl/laplacian_3x3_stream_filter_core.sv @@
// laplacian_3x3_stream_filter_core: 3x3 Laplacian over a raster pixel stream.
// Throughput: one item per cycle while the output does not stall; the line store takes one
// read and one write a cycle. Results pass the queue, s1, s2, s3 and the output register;
// results lag the input stream by frame width + 1 items.
// Reset (rst_n, synchronous, active low): counters, window and queue clear, mode 0,
// width and height 1024. The line store needs no clearing pass.
`timescale 1ns / 1ps

module laplacian_3x3_stream_filter_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lap3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lap3_pkg::CFG_DIM_W-1:0] cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [PIXEL_BITS-1:0]          in_pixel,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [PIXEL_BITS+3:0]   out_laplacian,
  output logic                           out_frame_done
);
  import lap3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int FW = $bits(lap3_flags_t);
  localparam int QW = PIXEL_BITS + AW + FW;

  logic                 neighbour_mode_r;
  logic [CFG_DIM_W-1:0] frame_width_r, frame_height_r;

  logic                  q_push, q_pop, q_full, q_empty;
  logic [PIXEL_BITS-1:0] f_pixel, b_pixel;
  logic [AW-1:0]         f_addr, b_addr;
  lap3_flags_t           f_flags, b_flags;
  logic [QW-1:0]         q_in, q_out;

  // Configuration registers; ready is tied high, so a write lands at the transfer edge.
  // Write only while no item is in flight.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neighbour_mode_r <= RST_NEIGHBOUR_MODE;
      frame_width_r    <= RST_FRAME_WIDTH;
      frame_height_r   <= RST_FRAME_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_NEIGHBOUR_MODE: neighbour_mode_r <= cfg_data[0];
        CFG_FRAME_WIDTH:    frame_width_r    <= cfg_data;
        CFG_FRAME_HEIGHT:   frame_height_r   <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Front: accept, count position, classify.
  lap3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS),
    .AW         (AW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_pixel     (in_pixel),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_pixel      (f_pixel),
    .q_addr       (f_addr),
    .q_flags      (f_flags)
  );

  // Queue decouples a stalled output from the input side.
  assign q_in = {f_pixel, f_addr, f_flags};

  lap3_queue #(
    .DW (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign b_pixel = q_out[QW-1 -: PIXEL_BITS];
  assign b_addr  = q_out[FW +: AW];
  assign b_flags = lap3_flags_t'(q_out[FW-1:0]);

  // Back: line store, window, kernel and output register.
  lap3_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .AW         (AW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .neighbour_mode (neighbour_mode_r),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_pixel        (b_pixel),
    .q_addr         (b_addr),
    .q_flags        (b_flags),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_laplacian  (out_laplacian),
    .out_frame_done (out_frame_done)
  );

endmodule
